### design/running_median_two_heaps_core_assert.svh
// Assertion macros for the running median core
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RMTH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define RMTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rmth_pkg.sv
// Shared constants and types of the running median core
`default_nettype none

package rmth_pkg;

   localparam int MAX_SAMPLES_DEF  = 1024;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int DATA_W           = 32;

   // Command to one heap engine
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } heap_cmd_type;

endpackage

`default_nettype wire

### design/rmth_heap.sv
// One binary heap in a memory with a sift-up / sift-down sequencer
`default_nettype none

module rmth_heap import rmth_pkg::*; #(
   parameter int W      = SAMPLE_WIDTH_DEF,
   parameter int DEPTH  = MAX_SAMPLES_DEF / 2 + 2,
   parameter int CW     = $clog2(DEPTH + 1),
   parameter bit IS_MAX = 1'b1
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire heap_cmd_type   cmd,
   input  wire logic [W-1:0]   cmd_value,
   output logic                busy,
   output logic [CW-1:0]       count,
   output logic [W-1:0]        top
);

   localparam int AW = $clog2(DEPTH);
   localparam int XW = AW + 2;

   localparam logic [2:0] H_IDLE    = 3'd0;
   localparam logic [2:0] H_UP_RD   = 3'd1;
   localparam logic [2:0] H_UP_CMP  = 3'd2;
   localparam logic [2:0] H_DN_LAST = 3'd3;
   localparam logic [2:0] H_DN_L    = 3'd4;
   localparam logic [2:0] H_DN_R    = 3'd5;
   localparam logic [2:0] H_DN_CMP  = 3'd6;

   logic [W-1:0]  mem [DEPTH];
   logic [W-1:0]  rd_ff;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic [W-1:0]  val_ff, val_in;
   logic [W-1:0]  bval_ff, bval_in;
   logic          btake_ff, btake_in;
   logic [W-1:0]  top_ff;

   logic          we;
   logic [AW-1:0] wa, ra;
   logic [W-1:0]  wd;
   logic [AW-1:0] parent;
   logic [XW-1:0] lx, rx, nx;
   logic          do_dec, dec_take;
   logic [AW-1:0] dec_idx;
   logic [W-1:0]  dec_val;
   logic [CW-1:0] cnt_dec;

   // True if a belongs above b in this heap
   function automatic logic rank(input logic [W-1:0] a, input logic [W-1:0] b);
      logic r;
      if (IS_MAX) begin
         r = $signed(a) > $signed(b);
      end else begin
         r = $signed(a) < $signed(b);
      end
      return r;
   endfunction

   assign parent  = (idx_ff - AW'(1)) >> 1;
   assign lx      = XW'({idx_ff, 1'b1});
   assign rx      = lx + XW'(1);
   assign nx      = XW'(n_ff);
   assign cnt_dec = count_ff - CW'(1);

   // Sequence one clear, push or pop, one memory read and compare per step
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      bidx_in  = bidx_ff;
      val_in   = val_ff;
      bval_in  = bval_ff;
      btake_in = btake_ff;
      we       = 1'b0;
      wa       = idx_ff;
      wd       = val_ff;
      ra       = '0;
      do_dec   = 1'b0;
      dec_take = 1'b0;
      dec_idx  = idx_ff;
      dec_val  = val_ff;
      case (state_ff)
         H_IDLE: begin
            if (cmd.clear) begin
               count_in = '0;
            end else if (cmd.push) begin
               val_in   = cmd_value;
               count_in = count_ff + CW'(1);
               idx_in   = count_ff[AW-1:0];
               if (count_ff == '0) begin
                  we = 1'b1;
                  wa = '0;
                  wd = cmd_value;
               end else begin
                  state_in = H_UP_RD;
               end
            end else if (cmd.pop && count_ff != '0) begin
               count_in = cnt_dec;
               n_in     = cnt_dec;
               idx_in   = '0;
               if (cnt_dec != '0) begin
                  ra       = cnt_dec[AW-1:0];
                  state_in = H_DN_LAST;
               end
            end
         end
         H_UP_RD: begin
            if (idx_ff == '0) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               ra       = parent;
               state_in = H_UP_CMP;
            end
         end
         H_UP_CMP: begin
            we = 1'b1;
            if (rank(val_ff, rd_ff)) begin
               wd       = rd_ff;
               idx_in   = parent;
               state_in = H_UP_RD;
            end else begin
               state_in = H_IDLE;
            end
         end
         H_DN_LAST: begin
            val_in   = rd_ff;
            state_in = H_DN_L;
         end
         H_DN_L: begin
            if (lx >= nx) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               ra       = lx[AW-1:0];
               state_in = H_DN_R;
            end
         end
         H_DN_R: begin
            btake_in = rank(rd_ff, val_ff);
            bidx_in  = lx[AW-1:0];
            bval_in  = btake_in ? rd_ff : val_ff;
            if (rx < nx) begin
               ra       = rx[AW-1:0];
               state_in = H_DN_CMP;
            end else begin
               do_dec   = 1'b1;
               dec_take = btake_in;
               dec_idx  = lx[AW-1:0];
               dec_val  = rd_ff;
            end
         end
         H_DN_CMP: begin
            do_dec = 1'b1;
            if (rank(rd_ff, bval_ff)) begin
               dec_take = 1'b1;
               dec_idx  = rx[AW-1:0];
               dec_val  = rd_ff;
            end else begin
               dec_take = btake_ff;
               dec_idx  = bidx_ff;
               dec_val  = bval_ff;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
      // Move the chosen child up into the hole, or settle the carried value
      if (do_dec) begin
         we = 1'b1;
         if (dec_take) begin
            wd       = dec_val;
            idx_in   = dec_idx;
            state_in = H_DN_L;
         end else begin
            state_in = H_IDLE;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers and cached root
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      bidx_ff  <= bidx_in;
      val_ff   <= val_in;
      bval_ff  <= bval_in;
      btake_ff <= btake_in;
      if (we && wa == '0) begin
         top_ff <= wd;
      end
   end

   // Heap storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign busy  = (state_ff != H_IDLE);
   assign count = count_ff;
   assign top   = top_ff;

endmodule

`default_nettype wire

### design/running_median_two_heaps_core.sv
// Running median of a sample stream kept in a max-heap and a min-heap
//
// Input channel req_: one sample per transfer; req_tuser set starts a new
// sequence (both heaps are emptied before the sample is taken).
// Result channel rsp_: one result per sample: the median of all samples
// held so far and a reject flag, set when MAX_SAMPLES samples are already
// held; a rejected sample leaves the state as it was.
// Each sample takes a push into one heap, then at most one pop from one heap
// together with a push into the other. A push climbs level by level and a pop
// sinks level by level, each step bound by the heap memory's single read port.
// A rejected sample skips both heap steps. The next sample is taken only after
// the result of the last one has been registered.
// req_tready is low while a sample is in work. A finished result sits in the
// output register; the next sample is taken while it waits, and that one's
// result waits in turn until rsp_tready frees the register.
// Synchronous reset empties both heaps and drops any pending result.
`default_nettype none

module running_median_two_heaps_core import rmth_pkg::*; #(
   parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [31:0] sample
   input  wire logic              req_tuser,   // [0] start_new
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [31:0] median
   output logic                   rsp_tuser    // [0] rejected
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int DEPTH = MAX_SAMPLES / 2 + 2;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int TW    = CW + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS   = 3'd1;
   localparam logic [2:0] S_WAIT1 = 3'd2;
   localparam logic [2:0] S_BAL   = 3'd3;
   localparam logic [2:0] S_WAIT2 = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SW-1:0]     x_ff, x_in, x_new;
   logic              rej_ff, rej_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_rej_ff, rsp_rej_in;

   heap_cmd_type      lcmd, ucmd;
   logic [SW-1:0]     lval, uval;
   logic              lbusy, ubusy;
   logic [CW-1:0]     lcnt, ucnt;
   logic [SW-1:0]     ltop, utop;

   logic              accept;
   logic [SW:0]       sum, half;
   logic [SW-1:0]     med;
   logic [DATA_W-1:0] med_out;

   // Take the low sample bits, padded with zeros when wider than the port
   if (SW <= DATA_W) begin : g_in_narrow
      assign x_new = req_tdata[SW-1:0];
   end else begin : g_in_wide
      assign x_new = {{(SW - DATA_W){1'b0}}, req_tdata};
   end

   // Lower half: max-heap
   rmth_heap #(.W(SW), .DEPTH(DEPTH), .CW(CW), .IS_MAX(1'b1)) u_lower (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lcmd),
      .cmd_value (lval),
      .busy      (lbusy),
      .count     (lcnt),
      .top       (ltop)
   );

   // Upper half: min-heap
   rmth_heap #(.W(SW), .DEPTH(DEPTH), .CW(CW), .IS_MAX(1'b0)) u_upper (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ucmd),
      .cmd_value (uval),
      .busy      (ubusy),
      .count     (ucnt),
      .top       (utop)
   );

   // Median of the held samples, even count truncated toward zero
   assign sum  = {ltop[SW-1], ltop} + {utop[SW-1], utop};
   assign half = $signed(sum + (SW+1)'(sum[SW])) >>> 1;
   always_comb begin
      if (lcnt == '0) begin
         med = '0;
      end else if (lcnt > ucnt) begin
         med = ltop;
      end else begin
         med = half[SW-1:0];
      end
   end

   if (SW >= DATA_W) begin : g_out_wide
      assign med_out = med[DATA_W-1:0];
   end else begin : g_out_narrow
      assign med_out = {{(DATA_W - SW){1'b0}}, med};
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Sequence insert, rebalance and result
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_rej_in   = rsp_rej_ff;
      lcmd         = '0;
      ucmd         = '0;
      lval         = x_ff;
      uval         = x_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in       = x_new;
               lcmd.clear = req_tuser;
               ucmd.clear = req_tuser;
               state_in   = S_INS;
            end
         end
         S_INS: begin
            rej_in = 1'b0;
            if ((TW'(lcnt) + TW'(ucnt)) >= TW'(MAX_SAMPLES)) begin
               rej_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               if (lcnt == '0 || $signed(x_ff) <= $signed(ltop)) begin
                  lcmd.push = 1'b1;
               end else begin
                  ucmd.push = 1'b1;
               end
               state_in = S_WAIT1;
            end
         end
         S_WAIT1: begin
            if (!lbusy && !ubusy) begin
               state_in = S_BAL;
            end
         end
         S_BAL: begin
            if (TW'(lcnt) > TW'(ucnt) + TW'(1)) begin
               lcmd.pop  = 1'b1;
               ucmd.push = 1'b1;
               uval      = ltop;
               state_in  = S_WAIT2;
            end else if (lcnt < ucnt) begin
               ucmd.pop  = 1'b1;
               lcmd.push = 1'b1;
               lval      = utop;
               state_in  = S_WAIT2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WAIT2: begin
            if (!lbusy && !ubusy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = med_out;
               rsp_rej_in   = rej_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample and result payload
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_rej_ff;

`include "running_median_two_heaps_core_assert.svh"

   `RMTH_ASSERT_NOW(a_idle_heaps_quiet, clock, reset, state_ff == S_IDLE, !lbusy && !ubusy, "heap busy while core idle")
   `RMTH_ASSERT_NOW(a_balanced_at_done, clock, reset, state_ff == S_DONE && !rej_ff, lcnt == ucnt || TW'(lcnt) == TW'(ucnt) + TW'(1), "heaps out of balance")
   `RMTH_ASSERT_NEXT(a_busy_after_take, clock, reset, accept, !req_tready, "sample taken while previous in work")

endmodule

`default_nettype wire

### dv/median_checker.sv
// Checker for the running median core: predicts each result and compares it
`timescale 1ns / 100ps
`default_nettype none

module median_checker import rmth_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic              req_tuser,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [DATA_W-1:0] rsp_tdata,
   input  wire logic              rsp_tuser,
   output int                     fail_count,
   output int                     pending
);

   localparam int DEPTH = MAX_SAMPLES / 2 + 2;

   typedef struct packed {
      logic [DATA_W-1:0] median;
      logic              rejected;
   } median_result_type;

   // Predictor state: max-heap of the lower half, min-heap of the upper half
   logic signed [DATA_W-1:0] low_heap [DEPTH];
   logic signed [DATA_W-1:0] high_heap [DEPTH];
   int low_n, high_n;
   median_result_type expected_medians [$];

   function automatic bit ranks_above(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b, bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_insert(bit is_max, logic signed [DATA_W-1:0] v);
      int i;
      int p;
      logic signed [DATA_W-1:0] t;
      i = is_max ? low_n : high_n;
      if (is_max) begin
         low_heap[i] = v;
         low_n++;
      end else begin
         high_heap[i] = v;
         high_n++;
      end
      // sift up
      while (i > 0) begin
         p = (i - 1) / 2;
         if (is_max) begin
            if (!ranks_above(low_heap[i], low_heap[p], 1)) break;
            t = low_heap[i]; low_heap[i] = low_heap[p]; low_heap[p] = t;
         end else begin
            if (!ranks_above(high_heap[i], high_heap[p], 0)) break;
            t = high_heap[i]; high_heap[i] = high_heap[p]; high_heap[p] = t;
         end
         i = p;
      end
   endtask

   task automatic heap_extract(bit is_max, output logic signed [DATA_W-1:0] top);
      logic signed [DATA_W-1:0] h [DEPTH];
      logic signed [DATA_W-1:0] t;
      int n, i, l, r, best;
      h = is_max ? low_heap : high_heap;
      n = is_max ? low_n : high_n;
      top = h[0];
      n--;
      h[0] = h[n];
      i = 0;
      // sift down
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         best = i;
         if (l < n && ranks_above(h[l], h[best], is_max)) best = l;
         if (r < n && ranks_above(h[r], h[best], is_max)) best = r;
         if (best == i) break;
         t = h[i]; h[i] = h[best]; h[best] = t;
         i = best;
      end
      if (is_max) begin
         low_heap = h;
         low_n = n;
      end else begin
         high_heap = h;
         high_n = n;
      end
   endtask

   task automatic predict_median(logic signed [DATA_W-1:0] x, logic start_new);
      median_result_type r;
      logic signed [DATA_W-1:0] t;
      logic signed [DATA_W:0] sum;
      r.rejected = 1'b0;
      if (start_new) begin
         low_n = 0;
         high_n = 0;
      end
      if (low_n + high_n >= MAX_SAMPLES) begin
         r.rejected = 1'b1;
      end else begin
         if (low_n == 0 || x <= low_heap[0]) heap_insert(1, x);
         else heap_insert(0, x);
         // rebalance so the lower half holds equal or one more
         if (low_n > high_n + 1) begin
            heap_extract(1, t);
            heap_insert(0, t);
         end else if (low_n < high_n) begin
            heap_extract(0, t);
            heap_insert(1, t);
         end
      end
      if (low_n == 0) begin
         r.median = '0;
      end else if (low_n > high_n) begin
         r.median = low_heap[0];
      end else begin
         sum = low_heap[0] + high_heap[0];
         sum = sum / 2;
         r.median = sum[DATA_W-1:0];
      end
      expected_medians = {expected_medians, r};
   endtask

   assign pending = expected_medians.size();

   // Predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      median_result_type e;
      int errs;
      if (reset) begin
         low_n <= 0;
         high_n <= 0;
         fail_count <= 0;
      end else begin
         errs = 0;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_medians.size() == 0) begin
               $error("unexpected result transfer: median %0h", rsp_tdata);
               errs++;
            end else begin
               e = expected_medians.pop_front();
               if (rsp_tdata !== e.median) begin
                  $error("median: expected %0d, actual %0d",
                         $signed(e.median), $signed(rsp_tdata));
                  errs++;
               end
               if (rsp_tuser !== e.rejected) begin
                  $error("rejected: expected %0b, actual %0b", e.rejected, rsp_tuser);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
         if (req_tvalid && req_tready) predict_median(req_tdata, req_tuser);
      end
   end

endmodule

`default_nettype wire

### dv/testbench.sv
// Stimulus and verdict for the running median core
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import rmth_pkg::*;

   localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // [31:0] sample
   logic              req_tuser = 1'b0; // [0] start_new
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // [31:0] median
   logic              rsp_tuser;        // [0] rejected
   int                fail_count;
   int                pending;
   bit                steady_phase = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   running_median_two_heaps_core i_dut (.*);

   median_checker #(.MAX_SAMPLES(MAX_SAMPLES)) i_checker (.*);

   // Result side stalls at random, except in the steady phase
   always @(posedge clock)
      rsp_tready <= steady_phase || ($urandom_range(99) >= 10);

   // Present one sample and hold it until the transfer; valid stays up after it
   task automatic send_sample(logic [DATA_W-1:0] value, logic start_new);
      while (!steady_phase && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start_new;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [DATA_W-1:0] pick_value(int mode);
      case (mode)
         0: return $urandom;
         1: return DATA_W'($signed($urandom_range(40)) - 20);
         2: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   initial begin
      int mode;
      int run_len;
      int sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, even and odd counts, overflow-free sums, new start
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      send_sample(32'hFFFF_FFFD, 1'b0);
      send_sample(32'h5555_5555, 1'b1);
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'h0000_0005, 1'b0);
      send_sample(32'h0000_0005, 1'b0);

      // Fill to capacity, then overflow and restart from full heaps
      steady_phase = 1'b1;
      send_sample($urandom, 1'b1);
      for (int i = 1; i < MAX_SAMPLES; i++) send_sample(pick_value(i % 4), 1'b0);
      steady_phase = 1'b0;
      repeat (6) send_sample(pick_value($urandom_range(3)), 1'b0);
      send_sample(32'h0000_0001, 1'b1);

      // Random runs of mixed length and value style
      sent = 0;
      while (sent < 750) begin
         run_len = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(40);
         mode = $urandom_range(3);
         send_sample(pick_value(mode), 1'b1);
         for (int i = 0; i < run_len; i++) begin
            send_sample(pick_value($urandom_range(7) == 0 ? $urandom_range(3) : mode),
                        1'b0);
         end
         sent += run_len + 1;
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/rmth_pkg.sv
design/rmth_heap.sv
design/running_median_two_heaps_core.sv
dv/median_checker.sv
dv/testbench.sv
